FILE: design/cbd_pkg.sv
// cbd_pkg: shared types and codes for the ring-buffer deque.
// Holds operation and status codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package cbd_pkg;

	// operation codes of an input beat
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_INSPECT    = 3'd4;

	// status codes of a result beat
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_EMPTY_POP = 2'd1;
	localparam logic [1:0] STAT_FULL_PUSH = 2'd2;

	localparam int WORD_W  = 32;
	localparam int COUNT_W = 10;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_RD_FRONT,
		CS_RD_BACK,
		CS_EXEC
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch the input beat
		logic rd_front;  // read the entry at the head pointer
		logic rd_back;   // read the entry before the tail pointer
		logic exec;      // apply the operation and load the result
	} cbd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;  // result register full and stalled
	} cbd_stat_t;

endpackage

FILE: design/cbd_ctrl.sv
// cbd_ctrl: sequencing state machine for the ring-buffer deque.
// Issues load, read and execute commands to cbd_datapath.
// Depends on cbd_pkg.
module cbd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cbd_pkg::cbd_stat_t  stat,
	output cbd_pkg::cbd_cmd_t   cmd
);

	cbd_pkg::ctrl_state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbd_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cbd_pkg::CS_IDLE: begin
				if (in_valid) state_d = cbd_pkg::CS_RD_FRONT;
			end
			cbd_pkg::CS_RD_FRONT: state_d = cbd_pkg::CS_RD_BACK;
			cbd_pkg::CS_RD_BACK:  state_d = cbd_pkg::CS_EXEC;
			cbd_pkg::CS_EXEC: begin
				if (!stat.out_busy) state_d = cbd_pkg::CS_IDLE;
			end
			default: state_d = cbd_pkg::CS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			cbd_pkg::CS_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			cbd_pkg::CS_RD_FRONT: cmd.rd_front = 1'b1;
			cbd_pkg::CS_RD_BACK:  cmd.rd_back  = 1'b1;
			cbd_pkg::CS_EXEC:     cmd.exec     = !stat.out_busy;
			default: in_stall = 1'b1;
		endcase
	end

endmodule

FILE: design/cbd_datapath.sv
// cbd_datapath: ring store, head/tail pointers and result register.
// Acts on commands from cbd_ctrl; reports result-register backpressure.
// Depends on cbd_pkg.
module cbd_datapath #(
	parameter int DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cbd_pkg::cbd_cmd_t                   cmd,
	output cbd_pkg::cbd_stat_t                  stat,
	input  logic [2:0]                          operation,
	input  logic signed [cbd_pkg::WORD_W-1:0]   push_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [cbd_pkg::WORD_W-1:0]   popped_value,
	output logic [1:0]                          status,
	output logic [cbd_pkg::COUNT_W-1:0]         entry_count,
	output logic                                is_empty,
	output logic signed [cbd_pkg::WORD_W-1:0]   front_value,
	output logic signed [cbd_pkg::WORD_W-1:0]   back_value
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
	localparam logic [AW-1:0] DMAX  = AW'(DEPTH - 1);

	logic [cbd_pkg::WORD_W-1:0] mem [DEPTH];

	logic [AW-1:0]              head_q, tail_q;
	logic [2:0]                 op_q;
	logic [cbd_pkg::WORD_W-1:0] word_q;
	logic [cbd_pkg::WORD_W-1:0] rd_data_q;
	logic [cbd_pkg::WORD_W-1:0] front_q;
	logic                       out_valid_q;

	logic [AW-1:0]              head_inc, head_dec, tail_inc, tail_dec;
	logic [AW-1:0]              rd_addr, wr_addr, count;
	logic [AW+cbd_pkg::COUNT_W-1:0] count_ext;
	logic                       empty, full, wr_en;
	logic [AW-1:0]              head_d, tail_d;
	logic [cbd_pkg::WORD_W-1:0] front_w, back_w, popped_d;
	logic [1:0]                 status_d;

	// wrap the pointers at DEPTH
	assign head_inc = (head_q == LAST) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? LAST : head_q - AW'(1);
	assign tail_inc = (tail_q == LAST) ? '0 : tail_q + AW'(1);
	assign tail_dec = (tail_q == '0) ? LAST : tail_q - AW'(1);

	// occupancy before the operation
	assign count = (tail_q >= head_q) ? tail_q - head_q
	                                  : (LAST - head_q) + tail_q + AW'(1);
	assign count_ext = {{cbd_pkg::COUNT_W{1'b0}}, count};
	assign empty = (head_q == tail_q);
	assign full  = (count == DMAX);

	assign rd_addr = cmd.rd_front ? head_q : tail_dec;

	// latch the input beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			word_q <= push_value;
		end
	end

	// ring store: registered read, one write
	always_ff @(posedge clk) begin
		if (cmd.rd_front || cmd.rd_back) rd_data_q <= mem[rd_addr];
		if (wr_en) mem[wr_addr] <= word_q;
	end

	// hold the front word while the back word is read
	always_ff @(posedge clk) begin
		if (cmd.rd_back) front_q <= rd_data_q;
	end

	assign front_w = empty ? '1 : front_q;
	assign back_w  = empty ? '1 : rd_data_q;

	// decode the operation
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		popped_d = '1;
		status_d = cbd_pkg::STAT_DONE;
		case (op_q)
			cbd_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					status_d = cbd_pkg::STAT_FULL_PUSH;
				end else begin
					head_d  = head_dec;
					wr_addr = head_dec;
					wr_en   = cmd.exec;
				end
			end
			cbd_pkg::OP_PUSH_BACK: begin
				if (full) begin
					status_d = cbd_pkg::STAT_FULL_PUSH;
				end else begin
					tail_d  = tail_inc;
					wr_addr = tail_q;
					wr_en   = cmd.exec;
				end
			end
			cbd_pkg::OP_POP_FRONT: begin
				if (empty) begin
					status_d = cbd_pkg::STAT_EMPTY_POP;
				end else begin
					popped_d = front_q;
					head_d   = head_inc;
				end
			end
			cbd_pkg::OP_POP_BACK: begin
				if (empty) begin
					status_d = cbd_pkg::STAT_EMPTY_POP;
				end else begin
					popped_d = rd_data_q;
					tail_d   = tail_dec;
				end
			end
			default: status_d = cbd_pkg::STAT_DONE;
		endcase
	end

	// advance the pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cmd.exec) begin
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	// result beat valid: set on execute, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			popped_value <= popped_d;
			status       <= status_d;
			entry_count  <= count_ext[cbd_pkg::COUNT_W-1:0];
			is_empty     <= empty;
			front_value  <= front_w;
			back_value   <= back_w;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_busy = out_valid_q && out_stall;

endmodule

FILE: design/circular_buffer_deque.sv
// circular_buffer_deque: top level of the ring-buffer double-ended queue.
// Joins cbd_ctrl (sequencer) and cbd_datapath (store, pointers, result).
// Depends on cbd_pkg, cbd_ctrl, cbd_datapath.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_stall | operation, push_value
//  out     | out_valid/out_stall | popped_value, status, entry_count,
//          |                     | is_empty, front_value, back_value
//
// An item passes through four steps: accept, read of the front entry, read of the
// back entry, execute; the ring store's one read port with registered data sets this.
// The result register frees the sequencer, so the next item is taken while a
// result still waits; a stalled result holds execute until it drains.
// Reset clears both pointers and the sequencer; the store needs no clearing.
module circular_buffer_deque #(
	parameter int DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          operation,
	input  logic signed [cbd_pkg::WORD_W-1:0]   push_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [cbd_pkg::WORD_W-1:0]   popped_value,
	output logic [1:0]                          status,
	output logic [cbd_pkg::COUNT_W-1:0]         entry_count,
	output logic                                is_empty,
	output logic signed [cbd_pkg::WORD_W-1:0]   front_value,
	output logic signed [cbd_pkg::WORD_W-1:0]   back_value
);

	cbd_pkg::cbd_cmd_t  cmd;
	cbd_pkg::cbd_stat_t stat;

	cbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	cbd_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.operation    (operation),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_value (popped_value),
		.status       (status),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.front_value  (front_value),
		.back_value   (back_value)
	);

endmodule
